// ----- hw/rtl/r2fft_pkg.sv -----
// Shared types, constants and twiddle tables for the radix-2 frame FFT.
package r2fft_pkg;

    localparam int LOG2_MAX   = 10;
    localparam int POINTS_MAX = 1 << LOG2_MAX;
    localparam int TW_COUNT   = POINTS_MAX / 2;
    localparam int TW_HALF    = TW_COUNT / 2;
    localparam int AW         = LOG2_MAX;
    localparam int TW_AW      = LOG2_MAX - 1;
    localparam int LW         = 4;

    localparam logic [63:0] TWO_PI_Q30      = 64'd6746518852;
    localparam logic [63:0] ONE_Q30_U       = 64'd1073741824;
    localparam logic signed [31:0] INV_SQRT2_Q30 = 32'sd759250125;
    localparam logic signed [31:0] UNIT_Q30      = 32'sd1073741824;

    // configuration register indexes
    localparam logic [1:0] REG_INVERSE = 2'd0;
    localparam logic [1:0] REG_LOG2    = 2'd1;

    // first quarter wave plus the pi/2 point; the rest is mirrored
    typedef logic signed [31:0] tw_arr_t [TW_HALF+1];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_FRD,
        ST_FMUL,
        ST_FSUM,
        ST_FWRX,
        ST_FWRY
    } state_t;

    typedef enum logic [1:0] {
        WSRC_SAMPLE,
        WSRC_X,
        WSRC_Y
    } wsrc_t;

    typedef struct packed {
        logic            sample_load;
        logic            prod_load;
        logic            out_load;
        logic            out_ready;
        logic [AW-1:0]   out_index;
        logic            out_last;
        logic [LW-1:0]   eff_log2;
        logic            work_we;
        wsrc_t           work_src;
        logic [AW-1:0]   work_waddr;
        logic [AW-1:0]   xaddr;
        logic [AW-1:0]   yaddr;
        logic            tw_load;
        logic [TW_AW-1:0] tw_index;
        logic            inverse;
        logic            bf_mul;
        logic            bf_sum;
        logic            res_we;
        logic [AW-1:0]   res_raddr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Taylor series of cos or sin of 2*pi*k/POINTS_MAX in Q2.30
    function automatic logic signed [31:0] tw_point(input int k, input bit want_sin);
        logic [63:0]        a;
        logic [63:0]        t;
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic signed [63:0] v;
        int                 n;
        a = (64'(k) * TWO_PI_Q30 + (64'd1 << (LOG2_MAX - 1))) >> LOG2_MAX;
        t = ONE_Q30_U;
        c = $signed(ONE_Q30_U);
        s = 64'sd0;
        for (n = 1; n <= 20; n++) begin
            t = ((t * a) >> 30) / 64'(n);
            if ((n & 1) != 0)
                s = (((n >> 1) & 1) != 0) ? s - $signed(t) : s + $signed(t);
            else
                c = (((n >> 1) & 1) != 0) ? c - $signed(t) : c + $signed(t);
        end
        v = want_sin ? s : c;
        if (v > $signed(ONE_Q30_U))
            v = $signed(ONE_Q30_U);
        else if (v < -$signed(ONE_Q30_U))
            v = -$signed(ONE_Q30_U);
        return v[31:0];
    endfunction

    function automatic tw_arr_t tw_table(input bit want_sin);
        tw_arr_t r;
        int      k;
        for (k = 0; k <= TW_HALF; k++) begin
            r[k] = tw_point(k, want_sin);
        end
        return r;
    endfunction

    localparam tw_arr_t TW_COS = tw_table(1'b0);
    localparam tw_arr_t TW_SIN = tw_table(1'b1);

endpackage

// ----- hw/rtl/r2fft_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
module r2fft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/r2fft_dp.sv -----
// Datapath: input scaling, butterfly arithmetic, work/result buffers, output register.
module r2fft_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  r2fft_pkg::ctrl_cmd_t    cmd,
    output r2fft_pkg::dp_status_t   status,
    input  logic signed [23:0]      sample_re,
    input  logic signed [23:0]      sample_im,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      bin_re,
    output logic signed [31:0]      bin_im,
    output logic [r2fft_pkg::AW-1:0] bin_index,
    output logic                    ready_res,
    output logic                    frame_last
);

    localparam int AW    = r2fft_pkg::AW;
    localparam int TW_AW = r2fft_pkg::TW_AW;

    function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
        if (v > 37'sd2147483647)
            return 32'sh7fffffff;
        if (v < -37'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    logic signed [23:0] s_re_reg, s_im_reg;
    logic signed [54:0] p_re_reg, p_im_reg;
    logic signed [31:0] wr_reg, wi_reg;
    logic signed [31:0] xa_re_reg, xa_im_reg;
    logic signed [63:0] m_rr_reg, m_ii_reg, m_ri_reg, m_ir_reg;
    logic signed [35:0] t_re_reg, t_im_reg;
    logic               out_valid_reg;
    logic signed [31:0] bin_re_reg, bin_im_reg;
    logic [AW-1:0]      bin_index_reg;
    logic               ready_res_reg, frame_last_reg;

    logic [63:0]        work_wdata, work_rd_x, work_rd_y, res_rd;
    logic [AW-1:0]      work_waddr;
    logic signed [31:0] scale_k;
    logic [5:0]         scale_sh;
    logic signed [55:0] rnd_re, rnd_im;
    logic signed [31:0] sc_re, sc_im;
    logic signed [64:0] sum_re, sum_im;
    logic signed [31:0] bx_re, bx_im, by_re, by_im;
    logic signed [31:0] yre, yim;
    logic               tw_mirror;
    logic [TW_AW-1:0]   tw_fold;

    assign scale_k  = cmd.eff_log2[0] ? r2fft_pkg::INV_SQRT2_Q30 : r2fft_pkg::UNIT_Q30;
    assign scale_sh = 6'd30 + 6'(cmd.eff_log2 >> 1);

    // second quarter wave: cos(pi-a) = -cos(a), sin(pi-a) = sin(a)
    assign tw_mirror = cmd.tw_index > TW_AW'(r2fft_pkg::TW_HALF);
    assign tw_fold   = tw_mirror ? TW_AW'(10'(r2fft_pkg::TW_COUNT) - {1'b0, cmd.tw_index})
                                 : cmd.tw_index;

    always_comb
    begin
        rnd_re = (56'(p_re_reg) + (56'sd1 <<< (scale_sh - 6'd1))) >>> scale_sh;
        rnd_im = (56'(p_im_reg) + (56'sd1 <<< (scale_sh - 6'd1))) >>> scale_sh;
        sc_re  = rnd_re[31:0];
        sc_im  = rnd_im[31:0];
        sum_re = 65'(m_rr_reg) - 65'(m_ii_reg) + 65'sd536870912;
        sum_im = 65'(m_ri_reg) + 65'(m_ir_reg) + 65'sd536870912;
        bx_re  = sat37(37'(xa_re_reg) + 37'(t_re_reg));
        bx_im  = sat37(37'(xa_im_reg) + 37'(t_im_reg));
        by_re  = sat37(37'(xa_re_reg) - 37'(t_re_reg));
        by_im  = sat37(37'(xa_im_reg) - 37'(t_im_reg));
        yre    = work_rd_y[31:0];
        yim    = work_rd_y[63:32];
        case (cmd.work_src)
            r2fft_pkg::WSRC_SAMPLE:
            begin
                work_wdata = {sc_im, sc_re};
            end
            r2fft_pkg::WSRC_X:
            begin
                work_wdata = {bx_im, bx_re};
            end
            r2fft_pkg::WSRC_Y:
            begin
                work_wdata = {by_im, by_re};
            end
            default:
            begin
                work_wdata = {by_im, by_re};
            end
        endcase
    end

    assign work_waddr = cmd.work_waddr;

    r2fft_ram #(.WIDTH(64), .DEPTH(r2fft_pkg::POINTS_MAX)) u_work (
        .clk     (clk),
        .we      (cmd.work_we),
        .waddr   (work_waddr),
        .wdata   (work_wdata),
        .raddr_a (cmd.xaddr),
        .raddr_b (cmd.yaddr),
        .rdata_a (work_rd_x),
        .rdata_b (work_rd_y)
    );

    r2fft_ram #(.WIDTH(64), .DEPTH(r2fft_pkg::POINTS_MAX)) u_result (
        .clk     (clk),
        .we      (cmd.res_we),
        .waddr   (work_waddr),
        .wdata   (work_wdata),
        .raddr_a (cmd.res_raddr),
        .raddr_b (cmd.res_raddr),
        .rdata_a (res_rd),
        .rdata_b ()
    );

    always_ff @(posedge clk)
    begin
        if (cmd.sample_load)
        begin
            s_re_reg <= sample_re;
            s_im_reg <= sample_im;
        end
        if (cmd.prod_load)
        begin
            p_re_reg <= 55'(s_re_reg) * 55'(scale_k);
            p_im_reg <= 55'(s_im_reg) * 55'(scale_k);
        end
        if (cmd.tw_load)
        begin
            wr_reg <= tw_mirror ? -r2fft_pkg::TW_COS[tw_fold] : r2fft_pkg::TW_COS[tw_fold];
            wi_reg <= cmd.inverse ? r2fft_pkg::TW_SIN[tw_fold]
                                  : -r2fft_pkg::TW_SIN[tw_fold];
        end
        if (cmd.bf_mul)
        begin
            xa_re_reg <= work_rd_x[31:0];
            xa_im_reg <= work_rd_x[63:32];
            m_rr_reg  <= yre * wr_reg;
            m_ii_reg  <= yim * wi_reg;
            m_ri_reg  <= yre * wi_reg;
            m_ir_reg  <= yim * wr_reg;
        end
        if (cmd.bf_sum)
        begin
            t_re_reg <= 36'(sum_re >>> 30);
            t_im_reg <= 36'(sum_im >>> 30);
        end
        if (cmd.out_load)
        begin
            bin_re_reg     <= cmd.out_ready ? res_rd[31:0] : 32'sd0;
            bin_im_reg     <= cmd.out_ready ? res_rd[63:32] : 32'sd0;
            bin_index_reg  <= cmd.out_index;
            ready_res_reg  <= cmd.out_ready;
            frame_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign bin_re     = bin_re_reg;
    assign bin_im     = bin_im_reg;
    assign bin_index  = bin_index_reg;
    assign ready_res  = ready_res_reg;
    assign frame_last = frame_last_reg;

endmodule

// ----- hw/rtl/r2fft_ctrl.sv -----
// Controller: configuration registers, frame counting and the butterfly sequencer.
module r2fft_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [7:0]              cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  r2fft_pkg::dp_status_t   status,
    output r2fft_pkg::ctrl_cmd_t    cmd
);

    localparam int AW    = r2fft_pkg::AW;
    localparam int LW    = r2fft_pkg::LW;
    localparam int TW_AW = r2fft_pkg::TW_AW;

    function automatic logic [AW-1:0] rev_bits(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int i = 0; i < AW; i++)
        begin
            r[i] = v[AW-1-i];
        end
        return r;
    endfunction

    r2fft_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    count_reg, count_next;
    logic             have_frame_reg, have_frame_next;
    logic             inverse_reg;
    logic [LW-1:0]    log2_reg;
    logic             inv_run_reg, inv_run_next;
    logic [LW-1:0]    stage_reg, stage_next;
    logic [TW_AW-1:0] bfly_reg, bfly_next;

    logic [LW-1:0]    eff_l;
    logic [AW-1:0]    mask;
    logic [LW-1:0]    hbit;
    logic [AW-1:0]    kk, lowmask, j_val, xaddr, yaddr;
    logic             last_idx, last_bfly, last_stage, cfg_wr;

    always_comb
    begin
        if (log2_reg == '0)
            eff_l = LW'(1);
        else if (log2_reg > LW'(r2fft_pkg::LOG2_MAX))
            eff_l = LW'(r2fft_pkg::LOG2_MAX);
        else
            eff_l = log2_reg;
        mask       = AW'((32'd1 << eff_l) - 32'd1);
        last_idx   = count_reg == mask;
        hbit       = stage_reg - LW'(1);
        kk         = AW'(bfly_reg);
        lowmask    = AW'((32'd1 << hbit) - 32'd1);
        j_val      = kk & lowmask;
        xaddr      = ((kk >> hbit) << stage_reg) | j_val;
        yaddr      = xaddr | (AW'(1) << hbit);
        last_bfly  = bfly_reg == mask[AW-1:1];
        last_stage = stage_reg == eff_l;
    end

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        have_frame_next = have_frame_reg;
        inv_run_next    = inv_run_reg;
        stage_next      = stage_reg;
        bfly_next       = bfly_reg;
        in_ready        = 1'b0;

        cmd             = '0;
        cmd.eff_log2    = eff_l;
        cmd.out_ready   = have_frame_reg;
        cmd.out_index   = count_reg;
        cmd.out_last    = last_idx;
        cmd.xaddr       = xaddr;
        cmd.yaddr       = yaddr;
        cmd.tw_index    = TW_AW'(j_val << (LW'(r2fft_pkg::LOG2_MAX) - stage_reg));
        cmd.inverse     = inv_run_reg;
        cmd.res_raddr   = count_reg;
        cmd.work_src    = r2fft_pkg::WSRC_SAMPLE;
        cmd.work_waddr  = rev_bits(count_reg) >> (LW'(r2fft_pkg::LOG2_MAX) - eff_l);

        case (state_reg)
            r2fft_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.sample_load = in_valid;
                if (in_valid)
                begin
                    state_next = r2fft_pkg::ST_SCALE;
                end
            end
            r2fft_pkg::ST_SCALE:
            begin
                cmd.prod_load = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = r2fft_pkg::ST_WRITE;
                end
            end
            r2fft_pkg::ST_WRITE:
            begin
                cmd.work_we = 1'b1;
                if (last_idx)
                begin
                    count_next   = '0;
                    inv_run_next = inverse_reg;
                    stage_next   = LW'(1);
                    bfly_next    = '0;
                    state_next   = r2fft_pkg::ST_FRD;
                end
                else
                begin
                    count_next = count_reg + AW'(1);
                    state_next = r2fft_pkg::ST_IDLE;
                end
            end
            r2fft_pkg::ST_FRD:
            begin
                cmd.tw_load = 1'b1;
                state_next  = r2fft_pkg::ST_FMUL;
            end
            r2fft_pkg::ST_FMUL:
            begin
                cmd.bf_mul = 1'b1;
                state_next = r2fft_pkg::ST_FSUM;
            end
            r2fft_pkg::ST_FSUM:
            begin
                cmd.bf_sum = 1'b1;
                state_next = r2fft_pkg::ST_FWRX;
            end
            r2fft_pkg::ST_FWRX:
            begin
                cmd.work_we    = 1'b1;
                cmd.work_src   = r2fft_pkg::WSRC_X;
                cmd.work_waddr = xaddr;
                cmd.res_we     = last_stage;
                state_next     = r2fft_pkg::ST_FWRY;
            end
            r2fft_pkg::ST_FWRY:
            begin
                cmd.work_we    = 1'b1;
                cmd.work_src   = r2fft_pkg::WSRC_Y;
                cmd.work_waddr = yaddr;
                cmd.res_we     = last_stage;
                state_next     = r2fft_pkg::ST_FRD;
                if (!last_bfly)
                begin
                    bfly_next = bfly_reg + TW_AW'(1);
                end
                else if (!last_stage)
                begin
                    bfly_next  = '0;
                    stage_next = stage_reg + LW'(1);
                end
                else
                begin
                    have_frame_next = 1'b1;
                    state_next      = r2fft_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = r2fft_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= r2fft_pkg::ST_IDLE;
            count_reg      <= '0;
            have_frame_reg <= 1'b0;
            inverse_reg    <= 1'b0;
            log2_reg       <= LW'(r2fft_pkg::LOG2_MAX);
            inv_run_reg    <= 1'b0;
            stage_reg      <= LW'(1);
            bfly_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            inv_run_reg <= inv_run_next;
            stage_reg   <= stage_next;
            bfly_reg    <= bfly_next;
            if (cfg_wr && cfg_index == r2fft_pkg::REG_LOG2)
            begin
                log2_reg       <= cfg_data[LW-1:0];
                count_reg      <= '0;
                have_frame_reg <= 1'b0;
            end
            else
            begin
                count_reg      <= count_next;
                have_frame_reg <= have_frame_next;
            end
            if (cfg_wr && cfg_index == r2fft_pkg::REG_INVERSE)
            begin
                inverse_reg <= cfg_data[0];
            end
        end
    end

endmodule

// ----- hw/rtl/radix2_fft_frame_top.sv -----
// Each accepted sample beat passes through accept, scale and buffer write states
// before the next is taken; its result beat, the previous frame's bin, is registered
// in the scale state once the output register is free. The beat that completes a
// frame is followed by the FFT: each butterfly steps through twiddle load, multiply,
// sum, X write and Y write on one shared butterfly unit. Reset clears control state
// only; no result is valid (tuser low) until a full frame has been transformed.
// Top level of the framed radix-2 FFT.
module radix2_fft_frame_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample_re[23:0], sample_im[47:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // bin_re[31:0], bin_im[63:32], bin_index[73:64], zero pad
    output logic        m_axis_tuser,   // ready_res
    output logic        m_axis_tlast    // frame_last
);

    r2fft_pkg::ctrl_cmd_t  cmd;
    r2fft_pkg::dp_status_t status;

    logic signed [31:0]          bin_re, bin_im;
    logic [r2fft_pkg::AW-1:0]    bin_index;

    r2fft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    r2fft_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample_re  (s_axis_tdata[23:0]),
        .sample_im  (s_axis_tdata[47:24]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .bin_re     (bin_re),
        .bin_im     (bin_im),
        .bin_index  (bin_index),
        .ready_res  (m_axis_tuser),
        .frame_last (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, bin_index, bin_im, bin_re};

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result beat not presented");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_we |-> !s_axis_tready)
        else $error("result buffer written while taking samples");

    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (bin_re == 32'sd0 && bin_im == 32'sd0))
        else $error("nonzero bin before first frame");

endmodule
